>>> rtl/sha1_hash_engine_macros.svh
// ---------------------------------------------------------------------------
// SHA-1 hash engine assertion macros
// Shared concurrent assertion forms, sampled on clk and masked by rst.
// ---------------------------------------------------------------------------
`ifndef SHA1_HASH_ENGINE_MACROS_SVH
`define SHA1_HASH_ENGINE_MACROS_SVH

// Same-cycle implication.
`define SHA1_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SHA1_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sha1_pkg.sv
// ---------------------------------------------------------------------------
// SHA-1 package
// Constants, sequencer states and control structs for the SHA-1 engine.
// ---------------------------------------------------------------------------
package sha1_pkg;

  localparam int unsigned NumChain  = 5;
  localparam int unsigned NumSched  = 16;
  localparam int unsigned NumRounds = 80;

  localparam logic [6:0] LAST_ROUND = 7'(NumRounds - 1);
  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [2:0] LAST_WORD  = 3'(NumChain - 1);

  localparam logic [31:0] IV [NumChain] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_CH  = 32'h5A827999;
  localparam logic [31:0] K_PAR = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
  localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

  // Round group: 20 rounds each
  typedef enum logic [1:0] {
    GRP_CH   = 2'd0,
    GRP_PAR  = 2'd1,
    GRP_MAJ  = 2'd2,
    GRP_PAR2 = 2'd3
  } sha1_grp_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_PAD   = 3'd1,
    ST_ROUND = 3'd2,
    ST_FOLD  = 3'd3,
    ST_EMIT  = 3'd4
  } sha1_state_t;

  typedef struct packed {
    logic       wr;        // write one byte into the block
    logic [7:0] data;
    logic       word_end;  // byte completes a 32-bit word
    logic       step;      // advance the message schedule one round
  } sha1_sched_ctl_t;

  typedef struct packed {
    logic      start;      // load a..e from the chaining words
    logic      step;       // run one round
    logic      fold;       // add a..e into the chaining words
    logic      reload;     // restore the initial chaining words
    sha1_grp_t grp;
  } sha1_round_ctl_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

>>> rtl/sha1_sched.sv
// ---------------------------------------------------------------------------
// SHA-1 block buffer and message schedule
// Packs bytes into words and shifts them into a 16-word line that also
// generates the expanded schedule during the rounds.
// ---------------------------------------------------------------------------
module sha1_sched (
  input  logic                      clk,
  input  sha1_pkg::sha1_sched_ctl_t ctl,
  output logic [31:0]               w
);
  import sha1_pkg::*;

  logic [31:0] sline [NumSched];
  logic [23:0] acc;
  logic [31:0] shift_in;
  logic        shift_en;

  assign w = sline[0];

  always_comb begin
    shift_en = ctl.step || (ctl.wr && ctl.word_end);
    if (ctl.step) begin
      shift_in = rotl(sline[13] ^ sline[8] ^ sline[2] ^ sline[0], 1);
    end else begin
      shift_in = {acc, ctl.data};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr && !ctl.word_end) begin
      acc <= {acc[15:0], ctl.data};
    end
    if (shift_en) begin
      for (int i = 0; i < NumSched - 1; i++) begin
        sline[i] <= sline[i + 1];
      end
      sline[NumSched - 1] <= shift_in;
    end
  end

endmodule

>>> rtl/sha1_round.sv
// ---------------------------------------------------------------------------
// SHA-1 round unit
// One shared round datapath over a..e, plus the five chaining words.
// ---------------------------------------------------------------------------
module sha1_round (
  input  logic                      clk,
  input  logic                      rst,
  input  sha1_pkg::sha1_round_ctl_t ctl,
  input  logic [31:0]               w,
  input  logic [2:0]                word_sel,
  output logic [31:0]               digest
);
  import sha1_pkg::*;

  logic [31:0] h [NumChain];
  logic [31:0] a, b, c, d, e;
  logic [31:0] f, k, sum;

  always_comb begin
    unique case (ctl.grp)
      GRP_CH: begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end
      GRP_PAR: begin
        f = b ^ c ^ d;
        k = K_PAR;
      end
      GRP_MAJ: begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end
      GRP_PAR2: begin
        f = b ^ c ^ d;
        k = K_PAR2;
      end
      default: begin
        f = b ^ c ^ d;
        k = K_PAR2;
      end
    endcase
    sum = rotl(a, 5) + f + e + k + w;
  end

  always_comb begin
    if (word_sel > LAST_WORD) begin
      digest = h[NumChain - 1];
    end else begin
      digest = h[word_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (ctl.step) begin
      a <= sum;
      b <= a;
      c <= rotl(b, 30);
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.reload) begin
      for (int i = 0; i < NumChain; i++) begin
        h[i] <= IV[i];
      end
    end else if (ctl.fold) begin
      h[0] <= h[0] + a;
      h[1] <= h[1] + b;
      h[2] <= h[2] + c;
      h[3] <= h[3] + d;
      h[4] <= h[4] + e;
    end
  end

endmodule

>>> rtl/sha1_ctrl.sv
// ---------------------------------------------------------------------------
// SHA-1 sequencer
// Takes input beats, injects padding and length bytes, counts rounds and
// hands out the five digest words.
// ---------------------------------------------------------------------------
`include "sha1_hash_engine_macros.svh"

module sha1_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 data_byte,
  input  logic                       byte_valid,
  input  logic                       end_of_message,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 word_index,
  output logic                       last_word,
  output sha1_pkg::sha1_sched_ctl_t  sched_ctl,
  output sha1_pkg::sha1_round_ctl_t  round_ctl
);
  import sha1_pkg::*;

  sha1_state_t state, state_next;

  logic [63:0] count;
  logic [63:0] count_add;
  logic [63:0] len;
  logic [5:0]  pos;
  logic [6:0]  round;
  logic [2:0]  widx;
  logic        pad_on;
  logic        first;
  logic        final_blk;

  logic        in_acc;
  logic        out_acc;
  logic        len_byte;
  logic        blk_end;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign count_add = count + 64'(byte_valid);
  assign blk_end   = (pos == 6'd63);
  assign len_byte  = !first && final_blk && (pos[5:3] == 3'b111);

  assign word_index = widx;
  assign last_word  = (widx == LAST_WORD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next          = state;
    in_ready            = 1'b0;
    out_valid           = 1'b0;
    sched_ctl.wr        = 1'b0;
    sched_ctl.data      = data_byte;
    sched_ctl.word_end  = (pos[1:0] == 2'b11);
    sched_ctl.step      = 1'b0;
    round_ctl.start     = 1'b0;
    round_ctl.step      = 1'b0;
    round_ctl.fold      = 1'b0;
    round_ctl.reload    = 1'b0;
    if (round < 7'd20) begin
      round_ctl.grp = GRP_CH;
    end else if (round < 7'd40) begin
      round_ctl.grp = GRP_PAR;
    end else if (round < 7'd60) begin
      round_ctl.grp = GRP_MAJ;
    end else begin
      round_ctl.grp = GRP_PAR2;
    end

    unique case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        sched_ctl.wr = in_acc && byte_valid;
        if (in_acc) begin
          if (byte_valid && blk_end) begin
            round_ctl.start = 1'b1;
            state_next      = ST_ROUND;
          end else if (end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        sched_ctl.wr = 1'b1;
        if (first) begin
          sched_ctl.data = PAD_BYTE;
        end else if (len_byte) begin
          sched_ctl.data = len[63:56];
        end else begin
          sched_ctl.data = 8'h00;
        end
        if (blk_end) begin
          round_ctl.start = 1'b1;
          state_next      = ST_ROUND;
        end
      end
      ST_ROUND: begin
        sched_ctl.step = 1'b1;
        round_ctl.step = 1'b1;
        if (round == LAST_ROUND) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        round_ctl.fold = 1'b1;
        if (!pad_on) begin
          state_next = ST_IDLE;
        end else if (final_blk) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_acc && last_word) begin
          round_ctl.reload = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Byte position, length and padding bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pos       <= '0;
      round     <= '0;
      widx      <= '0;
      pad_on    <= 1'b0;
      first     <= 1'b0;
      final_blk <= 1'b0;
    end else begin
      if (sched_ctl.wr) begin
        pos <= pos + 6'd1;
      end
      if (round_ctl.start) begin
        round <= '0;
      end else if (round_ctl.step) begin
        round <= round + 7'd1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            count <= count_add;
            if (end_of_message) begin
              pad_on    <= 1'b1;
              first     <= 1'b1;
              final_blk <= 1'b0;
            end
          end
        end
        ST_PAD: begin
          if (first) begin
            first     <= 1'b0;
            final_blk <= (pos[5:3] != 3'b111);
          end
        end
        ST_FOLD: begin
          if (pad_on && !final_blk && !first) begin
            final_blk <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            if (last_word) begin
              widx   <= '0;
              count  <= '0;
              pad_on <= 1'b0;
            end else begin
              widx <= widx + 3'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Bit length, fed out one byte at a time from the top
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc && end_of_message) begin
      len <= {count_add[60:0], 3'b000};
    end else if (state == ST_PAD && len_byte) begin
      len <= {len[55:0], 8'h00};
    end
  end

  `SHA1_ASSERT_NEXT(a_fold_after_last, (state == ST_ROUND && round == LAST_ROUND), (state == ST_FOLD), "fold must follow the last round")
  `SHA1_ASSERT_NOW(a_emit_aligned, (state == ST_EMIT), (pos == 6'd0 && pad_on && final_blk), "digest out of a misaligned or unpadded block")
  `SHA1_ASSERT_NOW(a_round_range, (state == ST_ROUND), (round <= LAST_ROUND), "round counter out of range")
  `SHA1_ASSERT_NEXT(a_idle_after_digest, (out_acc && last_word), (state == ST_IDLE && widx == 3'd0), "engine must return to idle after the final word")

endmodule

>>> rtl/sha1_hash_engine.sv
// ---------------------------------------------------------------------------
// SHA-1 hash engine
// Streaming SHA-1 digest: one message byte per beat in, five 32-bit digest
// words out per message, using a single shared round unit.
// ---------------------------------------------------------------------------
//
//   channel  handshake            payload
//   -------  -------------------  -------------------------------------------
//   input    in_valid / in_ready  data_byte, byte_valid, end_of_message
//   output   out_valid/out_ready  digest_word, word_index, last_word
//
// Timing: a closed 64-byte block loads a..e on its closing beat, then runs
//   80 rounds and a fold; padding injects one byte a cycle up to the end
//   of the block, and one or two final blocks are hashed before the first
//   digest word goes out.
// Reset: rst clears the sequencer and the byte count and loads the initial
//   chaining words; no clearing pass.
// Stalls: in_ready is high only while the engine waits for bytes; a digest
//   word holds on the output until taken, and the five words go out in order.
//
module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha1_pkg::*;

  sha1_sched_ctl_t sched_ctl;
  sha1_round_ctl_t round_ctl;
  logic [31:0]     w;

  // Sequencer: handshakes, padding, round count
  sha1_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .word_index     (word_index),
    .last_word      (last_word),
    .sched_ctl      (sched_ctl),
    .round_ctl      (round_ctl)
  );

  // Block buffer doubling as the rolling schedule
  sha1_sched u_sched (
    .clk (clk),
    .ctl (sched_ctl),
    .w   (w)
  );

  // Shared round datapath and chaining words; the digest is read straight
  // from the chaining registers, so it holds while out_ready is low
  sha1_round u_round (
    .clk      (clk),
    .rst      (rst),
    .ctl      (round_ctl),
    .w        (w),
    .word_sel (word_index),
    .digest   (digest_word)
  );

endmodule
